### rtl/spsp_pkg.sv
// Shared types and constants for the single-pair shortest path engine.
// Holds the command and result item structs, the sequencer states and codes.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package spsp_pkg;

  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 22;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam int MAX_NODES_DEF   = 64;
  localparam int MAX_EDGES_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOPATH = 2'd2
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [NODE_W-1:0]   edge_from;
    logic [NODE_W-1:0]   edge_to;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   start_node;
    logic [NODE_W-1:0]   end_node;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [DIST_W-1:0] distance;
    logic [NODE_W-1:0] path_node;
    logic              last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_PICK,
    S_RELAX,
    S_WALK_RD,
    S_WALK,
    S_EMIT,
    S_DRAIN
  } state_t;

endpackage

### rtl/single_pair_shortest_path.sv
// Top level of the single-pair shortest path engine: edge store, node store,
// path buffer and the sequencer that runs the settle, relax and walk phases.
// Depends on spsp_pkg for the item structs, codes and states.
//
//   channel   signals            direction  handshake
//   command   start, busy, cmd   in         taken when start is high, busy low
//   result    done, res          out        done strobe per item, no back-pressure
//
// Add edge and clear answer with one item in the cycle after the command.
// A query initializes the node store, then for each settled node runs a scan,
// a pick and, unless the edge store is empty, a relax pass over the edge store.
// The path walk reads each predecessor; the path items follow one a cycle.
// Reset only empties the edge store count; no clearing pass is needed.
`timescale 1ns / 1ps

module single_pair_shortest_path #(
  parameter int MAX_NODES   = spsp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = spsp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = spsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  spsp_pkg::cmd_t cmd,
  output logic           done,
  output spsp_pkg::rsp_t res
);

  import spsp_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EB = $clog2(MAX_EDGES + 1);
  localparam int DW = WEIGHT_BITS + NB;
  localparam int CW = (NB > NODE_W) ? NB : NODE_W;

  typedef struct packed {
    logic [NODE_W-1:0]      src;
    logic [NODE_W-1:0]      tgt;
    logic [WEIGHT_BITS-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic          reached;
    logic          settled;
    logic [NB-1:0] pred;
    logic [DW-1:0] path_cost;
  } node_t;

  edge_t edge_mem [MAX_EDGES];
  node_t node_mem [MAX_NODES];
  logic [NB-1:0] path_mem [MAX_NODES];

  state_t state, state_next;

  logic [EB-1:0] edge_count;
  logic [NB:0]   cnt;
  logic          rd_pend;
  logic [NB-1:0] rd_idx;
  logic          found;
  logic [NB-1:0] best_u;
  logic [NB-1:0] best_pred;
  logic [DW-1:0] best_dist;
  logic [NB-1:0] q_s;
  logic [NB-1:0] q_e;

  logic [EB-1:0]          ecnt;
  logic                   e_pend;
  logic                   n_pend;
  logic [NB-1:0]          n_tgt;
  logic [WEIGHT_BITS-1:0] n_cost;
  logic                   fwd_valid;
  logic [NB-1:0]          fwd_addr;
  node_t                  fwd_word;

  logic [NB-1:0] walk_t;
  logic [NB-1:0] plen;
  logic [NB-1:0] emit_k;
  logic          pend1;
  logic          last1;
  logic [NB-1:0] buf_q;

  edge_t edge_q;
  node_t node_q;
  rsp_t  out_q;

  logic          accept;
  logic          edge_hit;
  logic          edge_ok;
  logic          q_bad;
  logic          relax_more;
  logic          walk_end;
  node_t         relax_word;
  logic [DW-1:0] relax_d;
  logic          relax_upd;

  logic          edge_we;
  logic [EA-1:0] edge_raddr;
  logic [NB-1:0] node_raddr;
  logic          node_we;
  logic [NB-1:0] node_waddr;
  node_t         node_wdata;
  logic          path_we;

  assign accept     = start && (state == S_IDLE);
  assign q_bad      = (32'(cmd.start_node) >= MAX_NODES) || (32'(cmd.end_node) >= MAX_NODES);
  assign edge_hit   = (CW'(edge_q.src) == CW'(best_u));
  assign edge_ok    = (32'(edge_q.tgt) < MAX_NODES);
  assign relax_more = (ecnt < edge_count);
  assign walk_end   = (walk_t == q_s) || (32'(plen) + 1 == MAX_NODES);

  // The node read for this edge was issued together with the previous edge's
  // write, so that write is forwarded when both hit the same node.
  assign relax_word = (fwd_valid && (fwd_addr == n_tgt)) ? fwd_word : node_q;
  assign relax_d    = best_dist + DW'(n_cost);
  assign relax_upd  = !relax_word.settled &&
                      (!relax_word.reached || relax_d < relax_word.path_cost);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd.func == FUNC_QUERY) && !q_bad) state_next = S_INIT;
      end
      S_INIT: begin
        if (32'(cnt) == MAX_NODES - 1) state_next = S_SCAN;
      end
      S_SCAN: begin
        if ((32'(cnt) == MAX_NODES) && !rd_pend) state_next = S_PICK;
      end
      S_PICK: begin
        priority if (!found) state_next = S_IDLE;
        else if (best_u == q_e) state_next = S_WALK_RD;
        else if (edge_count != '0) state_next = S_RELAX;
        else state_next = S_SCAN;
      end
      S_RELAX: begin
        if (!relax_more && !e_pend && !n_pend) state_next = S_SCAN;
      end
      S_WALK_RD: state_next = S_WALK;
      S_WALK: begin
        state_next = walk_end ? S_EMIT : S_WALK_RD;
      end
      S_EMIT: begin
        if (emit_k == '0) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    busy       = (state != S_IDLE);
    edge_we    = 1'b0;
    edge_raddr = '0;
    node_raddr = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    path_we    = 1'b0;
    unique case (state)
      S_IDLE: begin
        edge_we = accept && (cmd.func == FUNC_ADD) && (32'(edge_count) != MAX_EDGES);
      end
      S_INIT: begin
        node_we              = 1'b1;
        node_waddr           = cnt[NB-1:0];
        node_wdata.reached   = (cnt[NB-1:0] == q_s);
        node_wdata.settled   = 1'b0;
        node_wdata.pred      = cnt[NB-1:0];
        node_wdata.path_cost = '0;
      end
      S_SCAN: begin
        if (32'(cnt) < MAX_NODES) node_raddr = cnt[NB-1:0];
      end
      S_PICK: begin
        node_we    = found;
        node_waddr = best_u;
        node_wdata = '{reached: 1'b1, settled: 1'b1, pred: best_pred,
                       path_cost: best_dist};
      end
      S_RELAX: begin
        if (relax_more) edge_raddr = ecnt[EA-1:0];
        if (e_pend && edge_ok) node_raddr = NB'(edge_q.tgt);
        node_we    = n_pend && relax_upd;
        node_waddr = n_tgt;
        node_wdata = '{reached: 1'b1, settled: 1'b0, pred: best_u, path_cost: relax_d};
      end
      S_WALK_RD: node_raddr = walk_t;
      S_WALK: path_we = 1'b1;
      S_EMIT, S_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_count[EA-1:0]] <= '{src: cmd.edge_from, tgt: cmd.edge_to,
                                        cost: WEIGHT_BITS'(cmd.edge_weight)};
    end
    edge_q <= edge_mem[edge_raddr];
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_q <= node_mem[node_raddr];
    if (path_we) path_mem[plen] <= walk_t;
    buf_q <= path_mem[emit_k];
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_count <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      e_pend     <= 1'b0;
      n_pend     <= 1'b0;
      fwd_valid  <= 1'b0;
      pend1      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      pend1 <= 1'b0;

      if (pend1) begin
        out_q <= '{status: ST_OK, distance: DIST_W'(best_dist),
                   path_node: NODE_W'(buf_q), last: last1};
        done  <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.func)
              FUNC_ADD: begin
                done  <= 1'b1;
                out_q <= '{status: (32'(edge_count) == MAX_EDGES) ? ST_FULL : ST_OK,
                           distance: '0, path_node: '0, last: 1'b1};
                if (32'(edge_count) != MAX_EDGES) edge_count <= edge_count + 1'b1;
              end
              FUNC_CLEAR: begin
                done       <= 1'b1;
                edge_count <= '0;
                out_q      <= '{status: ST_OK, distance: '0, path_node: '0, last: 1'b1};
              end
              FUNC_QUERY: begin
                if (q_bad) begin
                  done  <= 1'b1;
                  out_q <= '{status: ST_NOPATH, distance: '0, path_node: '0, last: 1'b1};
                end
                q_s <= NB'(cmd.start_node);
                q_e <= NB'(cmd.end_node);
                cnt <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == MAX_NODES - 1) begin
            cnt     <= '0;
            found   <= 1'b0;
            rd_pend <= 1'b0;
          end
        end
        S_SCAN: begin
          if (32'(cnt) < MAX_NODES) begin
            cnt     <= cnt + 1'b1;
            rd_pend <= 1'b1;
            rd_idx  <= cnt[NB-1:0];
          end else begin
            rd_pend <= 1'b0;
          end
          // Strict less-than keeps the lowest index on equal distances.
          if (rd_pend && node_q.reached && !node_q.settled &&
              (!found || node_q.path_cost < best_dist)) begin
            found     <= 1'b1;
            best_u    <= rd_idx;
            best_pred <= node_q.pred;
            best_dist <= node_q.path_cost;
          end
        end
        S_PICK: begin
          if (!found) begin
            done  <= 1'b1;
            out_q <= '{status: ST_NOPATH, distance: '0, path_node: '0, last: 1'b1};
          end
          walk_t    <= q_e;
          plen      <= '0;
          ecnt      <= '0;
          e_pend    <= 1'b0;
          n_pend    <= 1'b0;
          fwd_valid <= 1'b0;
          cnt       <= '0;
          found     <= 1'b0;
          rd_pend   <= 1'b0;
        end
        S_RELAX: begin
          if (relax_more) ecnt <= ecnt + 1'b1;
          e_pend    <= relax_more;
          n_pend    <= e_pend && edge_hit && edge_ok;
          n_tgt     <= NB'(edge_q.tgt);
          n_cost    <= edge_q.cost;
          fwd_valid <= node_we;
          fwd_addr  <= node_waddr;
          fwd_word  <= node_wdata;
        end
        S_WALK_RD: begin
        end
        S_WALK: begin
          plen <= plen + 1'b1;
          if (walk_end) emit_k <= plen;
          else walk_t <= node_q.pred;
        end
        S_EMIT: begin
          pend1 <= 1'b1;
          last1 <= (emit_k == '0);
          if (emit_k != '0) emit_k <= emit_k - 1'b1;
        end
        S_DRAIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign res = out_q;

endmodule

### dv/single_pair_shortest_path_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for single_pair_shortest_path. Edge loads, clears and path
// queries are checked against a Dijkstra search kept inside the bench.
// Depends on spsp_pkg and the single_pair_shortest_path RTL.

module single_pair_shortest_path_tb;
  import spsp_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int EDGES = MAX_EDGES_DEF;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 105;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  rsp_t res;

  cmd_t cmd_q[$];
  rsp_t answer_q[$];
  logic [1:0] hold = '0;
  int calm = 0;
  int fault_count = 0;
  int taken_count = 0;
  int total_items = 0;
  int useful_items = 0;
  int gen_edges = 0;
  longint cycle_count = 0;
  longint work_bound = 0;
  longint cycle_budget = 64'd100_000_000;

  // Mirror of the edge store, updated as items are accepted.
  logic [NODE_W-1:0]   store_src [EDGES];
  logic [NODE_W-1:0]   store_dst [EDGES];
  logic [WEIGHT_W-1:0] store_cost [EDGES];
  int store_count = 0;

  single_pair_shortest_path dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .res(res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void answer_add(input rsp_t r);
    answer_q = {answer_q, r};
  endfunction

  task automatic compute_answer(input cmd_t c);
    longint unsigned node_dist [NODES];
    bit node_seen [NODES];
    bit node_done [NODES];
    logic [NODE_W-1:0] node_prev [NODES];
    logic [NODE_W-1:0] trail [NODES];
    int trail_len;
    int u;
    int v;
    bit found;
    bit searching;
    longint unsigned d;
    logic [NODE_W-1:0] s;
    logic [NODE_W-1:0] e;
    logic [NODE_W-1:0] t;
    rsp_t r;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (c.func)
      FUNC_ADD: begin
        if (store_count >= EDGES) begin
          r.status = ST_FULL;
        end else begin
          store_src[store_count] = c.edge_from;
          store_dst[store_count] = c.edge_to;
          store_cost[store_count] = c.edge_weight;
          store_count++;
        end
        answer_add(r);
      end
      FUNC_CLEAR: begin
        store_count = 0;
        answer_add(r);
      end
      FUNC_QUERY: begin
        s = c.start_node;
        e = c.end_node;
        for (int i = 0; i < NODES; i++) begin
          node_dist[i] = 0;
          node_seen[i] = 1'b0;
          node_done[i] = 1'b0;
          node_prev[i] = NODE_W'(i);
        end
        node_seen[s] = 1'b1;
        searching = 1'b1;
        while (searching) begin
          found = 1'b0;
          u = 0;
          for (int i = 0; i < NODES; i++) begin
            if (node_seen[i] && !node_done[i] && (!found || node_dist[i] < node_dist[u])) begin
              u = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            searching = 1'b0;
          end else begin
            node_done[u] = 1'b1;
            if (u == e) begin
              searching = 1'b0;
            end else begin
              // Relax in load order; the predecessor moves only on a strict gain.
              for (int i = 0; i < store_count; i++) begin
                v = int'(store_dst[i]);
                if (store_src[i] == u && !node_done[v]) begin
                  d = node_dist[u] + store_cost[i];
                  if (!node_seen[v] || d < node_dist[v]) begin
                    node_seen[v] = 1'b1;
                    node_dist[v] = d;
                    node_prev[v] = NODE_W'(u);
                  end
                end
              end
            end
          end
        end
        if (!node_seen[e]) begin
          r.status = ST_NOPATH;
          answer_add(r);
        end else begin
          trail_len = 0;
          t = e;
          searching = 1'b1;
          while (searching) begin
            trail[trail_len] = t;
            trail_len++;
            if (t == s || trail_len >= NODES) searching = 1'b0;
            else t = node_prev[t];
          end
          d = node_dist[e];
          for (int i = 0; i < trail_len; i++) begin
            r.distance = d[DIST_W-1:0];
            r.path_node = trail[trail_len - 1 - i];
            r.last = (i == trail_len - 1);
            answer_add(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Unused fields carry random values so that every command bit moves.
  function automatic cmd_t scrambled();
    cmd_t c;
    c.func = FUNC_NONE;
    c.edge_from = NODE_W'($urandom_range(0, NODES - 1));
    c.edge_to = NODE_W'($urandom_range(0, NODES - 1));
    c.edge_weight = WEIGHT_W'($urandom_range(0, 65535));
    c.start_node = NODE_W'($urandom_range(0, NODES - 1));
    c.end_node = NODE_W'($urandom_range(0, NODES - 1));
    return c;
  endfunction

  function automatic void queue_item(input cmd_t c);
    cmd_q = {cmd_q, c};
    work_bound += 8;
    if (c.func != FUNC_NONE) useful_items++;
    if (c.func == FUNC_ADD && gen_edges < EDGES) gen_edges++;
    if (c.func == FUNC_CLEAR) gen_edges = 0;
    // Worst query: init, then per settled node a scan, a pick and a relax pass.
    if (c.func == FUNC_QUERY) work_bound += NODES * (NODES + 8 + gen_edges) + 4 * NODES;
  endfunction

  function automatic void add_edge(input int f, input int t, input int w);
    cmd_t c;
    c = scrambled();
    c.func = FUNC_ADD;
    c.edge_from = NODE_W'(f);
    c.edge_to = NODE_W'(t);
    c.edge_weight = WEIGHT_W'(w);
    queue_item(c);
  endfunction

  function automatic void ask(input int s, input int e);
    cmd_t c;
    c = scrambled();
    c.func = FUNC_QUERY;
    c.start_node = NODE_W'(s);
    c.end_node = NODE_W'(e);
    queue_item(c);
  endfunction

  function automatic void wipe();
    cmd_t c;
    c = scrambled();
    c.func = FUNC_CLEAR;
    queue_item(c);
  endfunction

  function automatic void junk();
    queue_item(scrambled());
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2, 3, 4: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 7));
    endcase
  endfunction

  always @(posedge clk) begin : feed_p
    logic go;
    go = start;
    if (rst) begin
      go = 1'b0;
      hold <= '0;
    end else begin
      if (start && !busy) go = 1'b0;
      if (!go) begin
        if (hold != 0) begin
          hold <= hold - 1'b1;
        end else if (cmd_q.size() != 0) begin
          cmd <= cmd_q.pop_front();
          go = 1'b1;
          // Occasional stretches of back-to-back items between random gaps.
          hold <= (calm > 0) ? 2'd0 : 2'($urandom_range(0, 3));
          calm <= (calm > 0) ? calm - 1 :
                  (($urandom_range(0, 7) == 0) ? int'($urandom_range(4, 16)) : 0);
        end
      end
    end
    start <= go;
  end

  always @(posedge clk) begin : watch_p
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (answer_q.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result: status %0d distance %0d node %0d last %0b",
                     res.status, res.distance, res.path_node, res.last);
        end else begin
          want = answer_q.pop_front();
          if (res.status !== want.status || res.distance !== want.distance ||
              res.path_node !== want.path_node || res.last !== want.last) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("exp/act status %0d/%0d distance %0d/%0d node %0d/%0d last %0b/%0b",
                       want.status, res.status, want.distance, res.distance,
                       want.path_node, res.path_node, want.last, res.last);
          end
        end
      end
      if (start && !busy) begin
        compute_answer(cmd);
        taken_count++;
      end
    end
  end

  always @(posedge clk) begin : watchdog_p
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_budget) begin
      $display("single_pair_shortest_path verification failed");
      $finish;
    end
  end

  initial begin : stimulus_p
    int pool [10];
    int k;
    int n_edges;
    int goal;

    // Directed part: empty store, ties, zero and full weights, self loop,
    // unreachable end, ignored selector and a query after a clear.
    ask(5, 5);
    ask(0, 63);
    add_edge(0, 1, 2);
    add_edge(0, 2, 1);
    add_edge(2, 1, 1);
    add_edge(1, 3, 1);
    add_edge(2, 3, 2);
    add_edge(3, 3, 0);
    add_edge(3, 63, 65535);
    add_edge(63, 0, 0);
    ask(0, 63);
    ask(0, 1);
    ask(0, 3);
    ask(1, 0);
    junk();
    ask(4, 0);
    wipe();
    ask(0, 1);
    add_edge(0, 0, 0);
    add_edge(63, 63, 65535);
    ask(63, 63);
    ask(0, 63);

    goal = useful_items + RANDOM_ITEMS;
    while (useful_items < goal) begin
      // Small graph on a random handful of nodes, then queries, mostly inside it.
      k = $urandom_range(3, 10);
      for (int j = 0; j < k; j++) pool[j] = $urandom_range(0, NODES - 1);
      if ($urandom_range(0, 4) != 0 || gen_edges > 200) wipe();
      if ($urandom_range(0, 1) == 1)
        for (int j = 0; j + 1 < k; j++) add_edge(pool[j], pool[j + 1], pick_weight());
      n_edges = $urandom_range(2, 2 * k);
      for (int j = 0; j < n_edges; j++) begin
        if ($urandom_range(0, 9) == 0) junk();
        add_edge(pool[$urandom_range(0, k - 1)], pool[$urandom_range(0, k - 1)],
                 pick_weight());
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 7) == 0)
          ask($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
        else
          ask(pool[$urandom_range(0, k - 1)], pool[$urandom_range(0, k - 1)]);
      end
      if ($urandom_range(0, 5) == 0) junk();
    end

    total_items = cmd_q.size();
    cycle_budget = 4 * work_bound + 1000;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (taken_count < total_items) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("single_pair_shortest_path verification clean");
    end else begin
      $display("single_pair_shortest_path verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spsp_pkg.sv
rtl/single_pair_shortest_path.sv
dv/single_pair_shortest_path_tb.sv
